// ===== rtl/lrws_pkg.sv =====
// Package for the lattice random walk stepper: widths, codes and helper functions.
`default_nettype none

package lrws_pkg;

    // Field and register widths
    localparam int RAND_BITS  = 16;
    localparam int COORD_BITS = 11;
    localparam int BOUND_W    = 10;
    localparam int PXY_W      = 15;
    localparam int PZ_W       = 16;
    localparam int PP_W       = 17;
    localparam int MODE_W     = 2;
    localparam int OUT_W      = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    // Probabilities are fractions of 2^PROB_SHIFT
    localparam int PROB_SHIFT = 16;
    // Widest cumulative threshold: 4 * prob_xy + prob_z
    localparam int THR_W      = 18;
    localparam int CMP_W      = RAND_BITS + THR_W;
    localparam int MAG_W      = (COORD_BITS > BOUND_W) ? COORD_BITS : BOUND_W;
    localparam int EXT_W      = (COORD_BITS > OUT_W) ? COORD_BITS : OUT_W;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [COORD_BITS-1:0]        coord_mag_t;
    typedef logic [BOUND_W-1:0]           bound_t;
    typedef logic [THR_W-1:0]             thr_t;
    typedef logic [MODE_W-1:0]            mode_t;
    typedef logic signed [OUT_W-1:0]      pos_t;

    // Walk modes
    localparam mode_t MODE_INTERIOR = 2'd0;
    localparam mode_t MODE_IFACE    = 2'd1;
    localparam mode_t MODE_CONV     = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOUND_X    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOUND_Y    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOUND_Z    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PROB_XY    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PROB_Z     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PROB_ZPLUS = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PROB_OUT   = 3'd7;

    // Register reset values
    localparam mode_t              RST_MODE       = MODE_INTERIOR;
    localparam bound_t             RST_BOUND      = 10'd10;
    localparam logic [PXY_W-1:0]   RST_PROB_XY    = 15'd10923;
    localparam logic [PZ_W-1:0]    RST_PROB_Z     = 16'd10923;
    localparam logic [PP_W-1:0]    RST_PROB_ZPLUS = 17'd32768;
    localparam logic [PP_W-1:0]    RST_PROB_OUT   = 17'd32768;

    // rnd / 2^RAND_BITS < thr / 2^PROB_SHIFT, exact
    function automatic logic below(logic [RAND_BITS-1:0] r, thr_t thr);
        logic [CMP_W-1:0] lhs;
        logic [CMP_W-1:0] rhs;
        lhs = CMP_W'(r) << PROB_SHIFT;
        rhs = CMP_W'(thr) << RAND_BITS;
        return lhs < rhs;
    endfunction

    // Magnitude of a two's complement coordinate (most negative value maps cleanly)
    function automatic coord_mag_t coord_mag(coord_t v);
        coord_mag_t u;
        u = coord_mag_t'(v);
        return v[COORD_BITS-1] ? (~u + coord_mag_t'(1)) : u;
    endfunction

    function automatic logic on_face(coord_t v, bound_t b);
        return MAG_W'(coord_mag(v)) >= MAG_W'(b);
    endfunction

    // Absorbing test; the top z face does not absorb in convective mode
    function automatic logic absorbed(coord_t x, coord_t y, coord_t z,
                                      bound_t bx, bound_t by, bound_t bz,
                                      mode_t mode);
        logic z_face;
        z_face = on_face(z, bz);
        return on_face(x, bx) || on_face(y, by)
            || (z[COORD_BITS-1] && z_face)
            || (!z[COORD_BITS-1] && z_face && (mode != MODE_CONV));
    endfunction

    // Sign-extend or truncate a coordinate to the output width
    function automatic pos_t to_pos(coord_t v);
        logic signed [EXT_W-1:0] ext;
        ext = EXT_W'(v);
        return ext[OUT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/lattice_random_walk_stepper.sv =====
// Lattice random walk stepper: 3-D walk stepped by one random fraction per transaction.
// Result path: the input transaction that ends the walk goes into the input register, then
//   through one pass of step logic into the result register, which raises out_valid.
// Throughput: one input transaction per cycle, limited only by output stall.
// Reset: walker at the origin, both stages empty, config registers at their defaults.
`default_nettype none

module lattice_random_walk_stepper (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // configuration write port
    input  wire logic                           cfg_wr_en,
    input  wire logic [lrws_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [lrws_pkg::CFG_DATA_W-1:0] cfg_data,
    // input channel
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [lrws_pkg::RAND_BITS-1:0] rnd,
    // output channel
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic signed [lrws_pkg::OUT_W-1:0]   pos_x,
    output logic signed [lrws_pkg::OUT_W-1:0]   pos_y,
    output logic signed [lrws_pkg::OUT_W-1:0]   pos_z,
    output logic                                escaped
);

    import lrws_pkg::*;

    // Configuration registers
    mode_t            mode_reg;
    bound_t           bound_x_reg;
    bound_t           bound_y_reg;
    bound_t           bound_z_reg;
    logic [PXY_W-1:0] prob_xy_reg;
    logic [PZ_W-1:0]  prob_z_reg;
    logic [PP_W-1:0]  prob_zplus_reg;
    logic [PP_W-1:0]  prob_out_reg;

    // Walker state
    coord_t cur_x_reg, cur_y_reg, cur_z_reg;
    coord_t cur_x_next, cur_y_next, cur_z_next;

    // Input stage
    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    logic [RAND_BITS-1:0] rnd_reg;

    // Result stage
    logic   out_valid_reg;
    logic   out_valid_next;
    pos_t   pos_x_reg, pos_y_reg, pos_z_reg;
    logic   escaped_reg;

    // Step logic
    logic   in_accept;
    logic   s1_adv;
    logic   emit;
    logic   emit_esc;
    coord_t step_x, step_y, step_z;
    coord_t res_x, res_y, res_z;
    thr_t   p1, p2, p3, p4, p5;
    logic   top_conv;

    // Handshake: the input stage moves on whenever the result slot is free or draining
    assign s1_adv    = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !s1_adv;
    assign in_accept = in_valid && !in_stall;

    assign s1_valid_next  = in_accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
    assign out_valid_next = (s1_adv && emit) ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);

    // Cumulative direction thresholds
    assign p1 = thr_t'(prob_xy_reg);
    assign p2 = p1 << 1;
    assign p3 = p1 + p2;
    assign p4 = p1 << 2;
    assign p5 = p4 + thr_t'(prob_z_reg);

    assign top_conv = (mode_reg == MODE_CONV) && !cur_z_reg[COORD_BITS-1]
                   && on_face(cur_z_reg, bound_z_reg);

    // One walk step on the current position
    always_comb
    begin
        step_x   = cur_x_reg;
        step_y   = cur_y_reg;
        step_z   = cur_z_reg;
        emit     = 1'b0;
        emit_esc = 1'b0;
        res_x    = cur_x_reg;
        res_y    = cur_y_reg;
        res_z    = cur_z_reg;

        if (absorbed(cur_x_reg, cur_y_reg, cur_z_reg,
                     bound_x_reg, bound_y_reg, bound_z_reg, mode_reg))
        begin
            // already on a face: report without moving
            emit = 1'b1;
        end
        else if (top_conv && below(rnd_reg, thr_t'(prob_out_reg)))
        begin
            // escape through the convective top face
            emit     = 1'b1;
            emit_esc = 1'b1;
            res_z    = coord_t'(bound_z_reg) + coord_t'(1);
        end
        else
        begin
            if (top_conv)
                step_z = cur_z_reg - coord_t'(1);
            else if ((mode_reg == MODE_IFACE) && (cur_z_reg == '0))
                step_z = below(rnd_reg, thr_t'(prob_zplus_reg)) ? coord_t'(1) : -coord_t'(1);
            else if (below(rnd_reg, p1))
                step_x = cur_x_reg + coord_t'(1);
            else if (below(rnd_reg, p2))
                step_x = cur_x_reg - coord_t'(1);
            else if (below(rnd_reg, p3))
                step_y = cur_y_reg + coord_t'(1);
            else if (below(rnd_reg, p4))
                step_y = cur_y_reg - coord_t'(1);
            else if (below(rnd_reg, p5))
                step_z = cur_z_reg + coord_t'(1);
            else
                step_z = cur_z_reg - coord_t'(1);

            res_x = step_x;
            res_y = step_y;
            res_z = step_z;
            emit  = absorbed(step_x, step_y, step_z,
                             bound_x_reg, bound_y_reg, bound_z_reg, mode_reg);
        end
    end

    // Walker returns to the origin after every reported walk
    always_comb
    begin
        cur_x_next = cur_x_reg;
        cur_y_next = cur_y_reg;
        cur_z_next = cur_z_reg;
        if (s1_adv)
        begin
            cur_x_next = emit ? '0 : step_x;
            cur_y_next = emit ? '0 : step_y;
            cur_z_next = emit ? '0 : step_z;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= RST_MODE;
            bound_x_reg    <= RST_BOUND;
            bound_y_reg    <= RST_BOUND;
            bound_z_reg    <= RST_BOUND;
            prob_xy_reg    <= RST_PROB_XY;
            prob_z_reg     <= RST_PROB_Z;
            prob_zplus_reg <= RST_PROB_ZPLUS;
            prob_out_reg   <= RST_PROB_OUT;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_MODE:       mode_reg       <= cfg_data[MODE_W-1:0];
                REG_BOUND_X:    bound_x_reg    <= cfg_data[BOUND_W-1:0];
                REG_BOUND_Y:    bound_y_reg    <= cfg_data[BOUND_W-1:0];
                REG_BOUND_Z:    bound_z_reg    <= cfg_data[BOUND_W-1:0];
                REG_PROB_XY:    prob_xy_reg    <= cfg_data[PXY_W-1:0];
                REG_PROB_Z:     prob_z_reg     <= cfg_data[PZ_W-1:0];
                REG_PROB_ZPLUS: prob_zplus_reg <= cfg_data[PP_W-1:0];
                REG_PROB_OUT:   prob_out_reg   <= cfg_data[PP_W-1:0];
                default:        ;
            endcase
        end
    end

    // Control and walker state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            cur_z_reg     <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            cur_z_reg     <= cur_z_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
            rnd_reg <= rnd;
        if (s1_adv && emit)
        begin
            pos_x_reg   <= to_pos(res_x);
            pos_y_reg   <= to_pos(res_y);
            pos_z_reg   <= emit_esc ? pos_t'(res_z[COORD_BITS-1:0] & coord_t'('1))
                                    : to_pos(res_z);
            escaped_reg <= emit_esc;
        end
    end

    assign out_valid = out_valid_reg;
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;
    assign pos_z     = pos_z_reg;
    assign escaped   = escaped_reg;

    // Checks
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled while a stage was free");

    a_origin_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && emit) |=> (cur_x_reg == '0 && cur_y_reg == '0 && cur_z_reg == '0))
        else $error("walker not returned to origin after a result");

    a_escape_needs_conv: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && escaped_reg) |-> (mode_reg == MODE_CONV))
        else $error("escape flagged outside convective mode");

    a_hold_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> ($stable(cur_x_reg) && $stable(cur_y_reg)
                                       && $stable(cur_z_reg)))
        else $error("walker moved while its step was held");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for the lattice random walk stepper: directed and random walks against a walk predictor.
module testbench;
    import lrws_pkg::*;

    // Mode 3 has no name in the package; it walks like the interior mode
    localparam mode_t                MODE_SPARE = 2'd3;
    localparam logic [RAND_BITS-1:0] RND_MAX    = '1;

    typedef struct {
        pos_t x;
        pos_t y;
        pos_t z;
        logic esc;
    } walk_end_t;

    // DUT ports
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    logic [RAND_BITS-1:0]  rnd       = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    pos_t                  pos_x;
    pos_t                  pos_y;
    pos_t                  pos_z;
    logic                  escaped;

    // Predictor copy of the registers and the walker
    mode_t            cfg_mode = RST_MODE;
    bound_t           lim_x    = RST_BOUND;
    bound_t           lim_y    = RST_BOUND;
    bound_t           lim_z    = RST_BOUND;
    logic [PXY_W-1:0] p_xy     = RST_PROB_XY;
    logic [PZ_W-1:0]  p_z      = RST_PROB_Z;
    logic [PP_W-1:0]  p_zplus  = RST_PROB_ZPLUS;
    logic [PP_W-1:0]  p_out    = RST_PROB_OUT;
    coord_t           walk_x   = '0;
    coord_t           walk_y   = '0;
    coord_t           walk_z   = '0;

    walk_end_t walk_ends[$];

    int error_count    = 0;
    int ends_predicted = 0;
    int ends_checked   = 0;
    int steps_sent     = 0;
    int reg_writes     = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;

    always #2 clk = ~clk;

    lattice_random_walk_stepper u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .rnd       (rnd),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z),
        .escaped   (escaped)
    );

    // ---------------------------------------------------------------
    // Walk predictor
    // ---------------------------------------------------------------
    function automatic int unsigned coord_abs(coord_t v);
        int s;
        s = v;
        return (s < 0) ? -s : s;
    endfunction

    // rnd / 2^RAND_BITS < thr / 2^PROB_SHIFT, kept exact in 64 bits
    function automatic logic frac_below(logic [RAND_BITS-1:0] r, int unsigned thr);
        longint unsigned lhs;
        longint unsigned rhs;
        lhs = longint'(r) << PROB_SHIFT;
        rhs = longint'(thr) << RAND_BITS;
        return lhs < rhs;
    endfunction

    // Top z face only absorbs outside the convective mode
    function automatic logic walker_on_face();
        if (coord_abs(walk_x) >= lim_x || coord_abs(walk_y) >= lim_y)
            return 1'b1;
        if (walk_z < 0)
            return coord_abs(walk_z) >= lim_z;
        return coord_abs(walk_z) >= lim_z && cfg_mode != MODE_CONV;
    endfunction

    function automatic void end_walk(pos_t z, logic esc);
        walk_end_t e;
        e.x   = walk_x;
        e.y   = walk_y;
        e.z   = z;
        e.esc = esc;
        walk_ends.insert(walk_ends.size(), e);
        ends_predicted++;
        walk_x = '0;
        walk_y = '0;
        walk_z = '0;
    endfunction

    // One accepted random fraction moves the walker, maybe ending the walk
    function automatic void walk_step(logic [RAND_BITS-1:0] r);
        int unsigned p;
        p = p_xy;
        if (walker_on_face())
        begin
            end_walk(walk_z, 1'b0);
            return;
        end
        if (cfg_mode == MODE_CONV && walk_z >= 0 && coord_abs(walk_z) >= lim_z)
        begin
            if (frac_below(r, p_out))
            begin
                end_walk(pos_t'(int'(lim_z) + 1), 1'b1);
                return;
            end
            walk_z = walk_z - coord_t'(1);
        end
        else if (cfg_mode == MODE_IFACE && walk_z == 0)
            walk_z = frac_below(r, p_zplus) ? coord_t'(1) : -coord_t'(1);
        else if (frac_below(r, p))
            walk_x = walk_x + coord_t'(1);
        else if (frac_below(r, 2 * p))
            walk_x = walk_x - coord_t'(1);
        else if (frac_below(r, 3 * p))
            walk_y = walk_y + coord_t'(1);
        else if (frac_below(r, 4 * p))
            walk_y = walk_y - coord_t'(1);
        else if (frac_below(r, 4 * p + p_z))
            walk_z = walk_z + coord_t'(1);
        else
            walk_z = walk_z - coord_t'(1);
        if (walker_on_face())
            end_walk(walk_z, 1'b0);
    endfunction

    // ---------------------------------------------------------------
    // Result checking and output stall
    // ---------------------------------------------------------------
    function automatic void check_field(string name, logic signed [31:0] want,
                                        logic signed [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin : check_walk_ends
        walk_end_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (walk_ends.size() == 0)
            begin
                $display("%0t: unexpected walk end, expected none, got (%0d,%0d,%0d) esc %0b",
                         $time, pos_x, pos_y, pos_z, escaped);
                error_count++;
            end
            else
            begin
                want = walk_ends.pop_front();
                check_field("pos_x", want.x, pos_x);
                check_field("pos_y", want.y, pos_y);
                check_field("pos_z", want.z, pos_z);
                check_field("escaped", want.esc, escaped);
                ends_checked++;
            end
        end
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    // Drop valid and let every pending walk end drain out of the pipe
    task automatic settle_walker();
        in_valid <= 1'b0;
        @(posedge clk);
        while (walk_ends.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        settle_walker();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_MODE:       cfg_mode = val[MODE_W-1:0];
            REG_BOUND_X:    lim_x    = val[BOUND_W-1:0];
            REG_BOUND_Y:    lim_y    = val[BOUND_W-1:0];
            REG_BOUND_Z:    lim_z    = val[BOUND_W-1:0];
            REG_PROB_XY:    p_xy     = val[PXY_W-1:0];
            REG_PROB_Z:     p_z      = val[PZ_W-1:0];
            REG_PROB_ZPLUS: p_zplus  = val[PP_W-1:0];
            REG_PROB_OUT:   p_out    = val[PP_W-1:0];
            default: ;
        endcase
        reg_writes++;
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // Send one random fraction; valid stays up until the next gap or drain
    task automatic step_rnd(input logic [RAND_BITS-1:0] v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rnd      <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        walk_step(v);
        steps_sent++;
    endtask

    // Uniform half the time; otherwise extremes or values right at a threshold
    function automatic logic [RAND_BITS-1:0] pick_rnd();
        longint t;
        case ($urandom_range(7))
            0: t = $urandom_range(1) ? RND_MAX : 0;
            1: t = longint'(p_xy) * $urandom_range(4, 1) - $urandom_range(1);
            2: t = longint'(4 * p_xy + p_z) - $urandom_range(1);
            3: t = longint'((cfg_mode == MODE_IFACE) ? p_zplus : p_out) - $urandom_range(1);
            default: t = $urandom_range(RND_MAX);
        endcase
        if (t < 0)
            t = 0;
        if (t > RND_MAX)
            t = RND_MAX;
        return t[RAND_BITS-1:0];
    endfunction

    // Probability register value: usual range, its ends, or anything the field holds
    function automatic logic [CFG_DATA_W-1:0] pick_level(int unsigned hi, int unsigned top);
        case ($urandom_range(9))
            0: return 0;
            1: return CFG_DATA_W'(hi);
            2: return CFG_DATA_W'($urandom_range(top));
            default: return CFG_DATA_W'($urandom_range(hi));
        endcase
    endfunction

    // Small faces keep walks short; zero and the far end show up now and then
    function automatic logic [CFG_DATA_W-1:0] pick_bound();
        case ($urandom_range(19))
            0: return 0;
            1: return CFG_DATA_W'((1 << BOUND_W) - 1);
            2: return CFG_DATA_W'($urandom_range((1 << BOUND_W) - 1));
            default: return CFG_DATA_W'($urandom_range(6, 1));
        endcase
    endfunction

    task automatic pick_random_config();
        write_reg(REG_MODE, CFG_DATA_W'($urandom_range(3)));
        write_reg(REG_BOUND_X, pick_bound());
        write_reg(REG_BOUND_Y, pick_bound());
        write_reg(REG_BOUND_Z, pick_bound());
        write_reg(REG_PROB_XY, pick_level(16384, (1 << PXY_W) - 1));
        write_reg(REG_PROB_Z, pick_level(32768, (1 << PZ_W) - 1));
        write_reg(REG_PROB_ZPLUS, pick_level(65536, (1 << PP_W) - 1));
        write_reg(REG_PROB_OUT, pick_level(65536, (1 << PP_W) - 1));
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // Reset settings, random extremes: one +x and one -z step, no walk end
    task automatic test_reset_defaults();
        step_rnd(0);
        step_rnd(RND_MAX);
        settle_walker();
    endtask

    // Unit faces, so every step ends a walk; values sit on both sides of each threshold.
    // The first step finds the walker already on a lowered face.
    task automatic test_step_directions();
        write_reg(REG_MODE, MODE_INTERIOR);
        write_reg(REG_BOUND_X, 1);
        write_reg(REG_BOUND_Y, 1);
        write_reg(REG_BOUND_Z, 1);
        write_reg(REG_PROB_XY, 10000);
        write_reg(REG_PROB_Z, 10000);
        step_rnd(0);
        step_rnd(9999);
        step_rnd(10000);
        step_rnd(19999);
        step_rnd(20000);
        step_rnd(29999);
        step_rnd(30000);
        step_rnd(39999);
        step_rnd(40000);
        step_rnd(49999);
        step_rnd(50000);
        step_rnd(RND_MAX);
        settle_walker();
    endtask

    // At the z=0 plane only z moves: always up, then always down
    task automatic test_interface_plane();
        write_reg(REG_MODE, MODE_IFACE);
        write_reg(REG_PROB_ZPLUS, 65536);
        step_rnd(RND_MAX);
        write_reg(REG_PROB_ZPLUS, 0);
        step_rnd(0);
        settle_walker();
    endtask

    // Top face: certain escape, then never escape so the walker steps back down
    task automatic test_convective_top();
        write_reg(REG_MODE, MODE_CONV);
        write_reg(REG_BOUND_Z, 1);
        write_reg(REG_PROB_XY, 0);
        write_reg(REG_PROB_Z, 65535);
        write_reg(REG_PROB_OUT, 65536);
        step_rnd(0);
        step_rnd(RND_MAX);
        write_reg(REG_PROB_OUT, 0);
        step_rnd(0);
        step_rnd(0);
        step_rnd(RND_MAX);
        settle_walker();
    endtask

    // Zero face, spare mode code, face lowered mid-walk, thresholds summing past one
    task automatic test_face_cases();
        write_reg(REG_MODE, MODE_SPARE);
        write_reg(REG_BOUND_X, 0);
        step_rnd(RND_MAX);
        write_reg(REG_MODE, MODE_INTERIOR);
        write_reg(REG_BOUND_X, 5);
        write_reg(REG_BOUND_Y, 5);
        write_reg(REG_BOUND_Z, 5);
        write_reg(REG_PROB_XY, 16384);
        step_rnd(0);
        write_reg(REG_BOUND_X, 1);
        step_rnd(0);
        write_reg(REG_BOUND_Y, 1);
        write_reg(REG_BOUND_Z, 1);
        write_reg(REG_PROB_XY, CFG_DATA_W'((1 << PXY_W) - 1));
        step_rnd(RND_MAX);
        settle_walker();
    endtask

    // Random settings under three idling patterns, then extra short walks if ends were few
    task automatic test_random_walks();
        int base;
        int extra;
        base = ends_predicted;
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 20 : (ph == 1) ? 54 : 0;
            recv_idle_pct = (ph == 0) ? 54 : (ph == 1) ? 20 : 0;
            repeat (5)
            begin
                pick_random_config();
                repeat (100) step_rnd(pick_rnd());
            end
        end
        extra = 0;
        while (ends_predicted - base < 48 && extra < 10)
        begin
            write_reg(REG_MODE, MODE_INTERIOR);
            write_reg(REG_BOUND_X, 2);
            write_reg(REG_BOUND_Y, 2);
            write_reg(REG_BOUND_Z, 2);
            write_reg(REG_PROB_XY, RST_PROB_XY);
            write_reg(REG_PROB_Z, RST_PROB_Z);
            repeat (100) step_rnd(pick_rnd());
            extra++;
        end
        settle_walker();
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin
        int directed_steps;
        send_idle_pct = 20;
        recv_idle_pct = 54;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_step_directions();
        test_interface_plane();
        test_convective_top();
        test_face_cases();
        directed_steps = steps_sent;
        test_random_walks();
        repeat (8) @(posedge clk);
        $display("ran %0d directed and %0d random walk steps across %0d register writes",
                 directed_steps, steps_sent - directed_steps, reg_writes);
        $display("checked %0d walk ends, %0d mismatches", ends_checked, error_count);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog
    initial
    begin
        #4000000;
        $display("timeout with %0d walk ends outstanding", walk_ends.size());
        $display("status: fail");
        $finish;
    end

endmodule

// ===== lattice_random_walk_stepper.f =====
rtl/lrws_pkg.sv
rtl/lattice_random_walk_stepper.sv
tb/testbench.sv
